[sv/gde_pkg.sv]
// Shared constants and codes for the graph walk and Euler check block.
// No dependencies; imported by graph_dfs_eulerian_check, both checkers and tb_top.
`default_nettype none
package gde_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 64;
    localparam int ENTRIES      = 2 * MAX_EDGES;
    localparam int MAX_OUT      = 16;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int EW           = $clog2(ENTRIES);
    localparam int CW           = $clog2(ENTRIES + 1);
    localparam int NVW          = 5;
    localparam int OCW          = $clog2(MAX_OUT + 1);
    localparam int SDW          = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_WALK  = 2'd1,
        CMD_EULER = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_BAD    = 2'd2;

    localparam logic [1:0] EU_NONE  = 2'd0;
    localparam logic [1:0] EU_PATH  = 2'd1;
    localparam logic [1:0] EU_CYCLE = 2'd2;
endpackage
`default_nettype wire

[sv/graph_dfs_eulerian_check.sv]
// Add edge writes one adjacency entry per endpoint (states S_ADD_A, S_ADD_B); clear acts in
// idle. A walk reads each adjacency entry and pops and emits vertices; an Euler check
// searches for the first vertex with edges, walks from it and then scans every vertex.
// Takes one command at a time: o_in_ready stays low until the command is finished. Synchronous
// active-low reset empties the graph and sets num_vertices 16.
// Depends on gde_pkg and gde_ram.
`default_nettype none
module graph_dfs_eulerian_check
    import gde_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [4:0] i_vertex_a,
    input  wire logic [4:0] i_vertex_b,
    input  wire logic       i_cfg_we,
    input  wire logic [4:0] i_cfg_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [1:0]      o_kind,
    output logic [3:0]      o_vertex,
    output logic [1:0]      o_euler_status,
    output logic            o_edges_dropped,
    output logic            o_last
);
    typedef enum logic [3:0] {
        S_IDLE, S_ADD_A, S_ADD_B, S_WALK_TOP, S_WALK_RD, S_EMIT,
        S_FLUSH, S_EU_FIND, S_EU_SCAN
    } t_state;

    t_state           r_state;
    logic [NVW-1:0]   r_num_v;
    logic [CW-1:0]    r_ec;
    logic             r_ovf;
    logic [7:0]       r_deg  [MAX_VERTICES];
    logic [EW-1:0]    r_head [MAX_VERTICES];
    logic [EW-1:0]    r_tail [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_visited;
    logic [EW-1:0]    r_stk_ptr  [MAX_VERTICES];
    logic [7:0]       r_stk_left [MAX_VERTICES];
    logic [SDW-1:0]   r_depth;
    logic [VW-1:0]    r_a, r_b, r_new;
    logic             r_walk_out;
    logic [OCW-1:0]   r_n;
    logic             r_pend_v;
    logic [1:0]       r_pend_kind, r_pend_status;
    logic [VW-1:0]    r_pend_vertex;
    logic [NVW-1:0]   r_i;
    logic [NVW-1:0]   r_odd;
    logic             r_bad;

    logic [NVW-1:0]   w_count;
    logic [VW-1:0]    w_top, w_own, w_nbv;
    logic             w_nb_we, w_nx_we, w_out_free, w_acc, w_load;
    logic [EW-1:0]    w_raddr, w_nx_waddr;
    logic [VW-1:0]    w_rd_nb;
    logic [EW-1:0]    w_rd_nx;

    assign w_count    = (r_num_v > NVW'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) : r_num_v;
    assign w_top      = VW'(r_depth - SDW'(1));
    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_load     = w_out_free && (((r_state == S_EMIT) && r_pend_v) || (r_state == S_FLUSH));
    assign w_own      = (r_state == S_ADD_A) ? r_a : r_b;
    assign w_nbv      = (r_state == S_ADD_A) ? r_b : r_a;
    assign w_nb_we    = (r_state == S_ADD_A) || (r_state == S_ADD_B);
    assign w_nx_we    = w_nb_we && (r_deg[w_own] != 8'd0);
    assign w_nx_waddr = r_tail[w_own];
    assign w_raddr    = r_stk_ptr[w_top];

    gde_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_nb_ram (
        .i_clk(i_clk), .i_we(w_nb_we), .i_waddr(r_ec[EW-1:0]), .i_wdata(w_nbv),
        .i_raddr(w_raddr), .o_rdata(w_rd_nb)
    );
    gde_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_nx_ram (
        .i_clk(i_clk), .i_we(w_nx_we), .i_waddr(w_nx_waddr), .i_wdata(r_ec[EW-1:0]),
        .i_raddr(w_raddr), .o_rdata(w_rd_nx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_v     <= NVW'(MAX_VERTICES);
            r_ec        <= '0;
            r_ovf       <= 1'b0;
            r_visited   <= '0;
            r_depth     <= '0;
            r_pend_v    <= 1'b0;
            o_out_valid <= 1'b0;
            for (int k = 0; k < MAX_VERTICES; k++) begin
                r_deg[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_num_v <= i_cfg_data;
            end
            if (o_out_valid && i_out_ready && !w_load) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        unique case (t_cmd'(i_cmd))
                            CMD_ADD: begin
                                if (i_vertex_a < w_count && i_vertex_b < w_count) begin
                                    if ({1'b0, r_ec} + (CW+1)'(2) > (CW+1)'(ENTRIES)) begin
                                        r_ovf <= 1'b1;
                                    end else begin
                                        r_a     <= VW'(i_vertex_a);
                                        r_b     <= VW'(i_vertex_b);
                                        r_state <= S_ADD_A;
                                    end
                                end
                            end
                            CMD_WALK: begin
                                if (i_vertex_a >= w_count) begin
                                    r_pend_v      <= 1'b1;
                                    r_pend_kind   <= KIND_BAD;
                                    r_pend_vertex <= '0;
                                    r_pend_status <= EU_NONE;
                                    r_state       <= S_FLUSH;
                                end else begin
                                    r_visited     <= MAX_VERTICES'(1) << i_vertex_a[VW-1:0];
                                    r_stk_ptr[0]  <= r_head[i_vertex_a[VW-1:0]];
                                    r_stk_left[0] <= r_deg[i_vertex_a[VW-1:0]];
                                    r_depth       <= SDW'(1);
                                    r_walk_out    <= 1'b1;
                                    r_n           <= '0;
                                    r_new         <= i_vertex_a[VW-1:0];
                                    r_state       <= S_EMIT;
                                end
                            end
                            CMD_EULER: begin
                                r_i     <= '0;
                                r_state <= S_EU_FIND;
                            end
                            CMD_CLEAR: begin
                                r_ec  <= '0;
                                r_ovf <= 1'b0;
                                for (int k = 0; k < MAX_VERTICES; k++) begin
                                    r_deg[k] <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ADD_A, S_ADD_B: begin
                    if (r_deg[w_own] == 8'd0) begin
                        r_head[w_own] <= r_ec[EW-1:0];
                    end
                    r_tail[w_own] <= r_ec[EW-1:0];
                    r_deg[w_own]  <= r_deg[w_own] + 8'd1;
                    r_ec          <= r_ec + CW'(1);
                    r_state       <= (r_state == S_ADD_A) ? S_ADD_B : S_IDLE;
                end
                S_WALK_TOP: begin
                    if (r_depth == '0) begin
                        if (r_walk_out) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_i     <= '0;
                            r_odd   <= '0;
                            r_bad   <= 1'b0;
                            r_state <= S_EU_SCAN;
                        end
                    end else if (r_stk_left[w_top] == 8'd0) begin
                        r_depth <= r_depth - SDW'(1);
                    end else begin
                        r_stk_left[w_top] <= r_stk_left[w_top] - 8'd1;
                        r_state           <= S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    if (r_stk_left[w_top] != 8'd0) begin
                        r_stk_ptr[w_top] <= w_rd_nx;
                    end
                    if (NVW'(w_rd_nb) < w_count && !r_visited[w_rd_nb]) begin
                        r_visited[w_rd_nb] <= 1'b1;
                        r_new              <= w_rd_nb;
                        if (r_depth < SDW'(MAX_VERTICES)) begin
                            r_stk_ptr[r_depth[VW-1:0]]  <= r_head[w_rd_nb];
                            r_stk_left[r_depth[VW-1:0]] <= r_deg[w_rd_nb];
                            r_depth <= r_depth + SDW'(1);
                        end
                    end
                    if (NVW'(w_rd_nb) < w_count && !r_visited[w_rd_nb] && r_walk_out &&
                        r_n < OCW'(MAX_OUT)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_WALK_TOP;
                    end
                end
                S_EMIT: begin
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            o_out_valid     <= 1'b1;
                            o_kind          <= r_pend_kind;
                            o_vertex        <= r_pend_vertex;
                            o_euler_status  <= r_pend_status;
                            o_edges_dropped <= r_ovf;
                            o_last          <= 1'b0;
                        end
                        r_pend_v      <= 1'b1;
                        r_pend_kind   <= KIND_VERTEX;
                        r_pend_vertex <= r_new;
                        r_pend_status <= EU_NONE;
                        r_n           <= r_n + OCW'(1);
                        r_state       <= S_WALK_TOP;
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        o_out_valid     <= 1'b1;
                        o_kind          <= r_pend_kind;
                        o_vertex        <= r_pend_vertex;
                        o_euler_status  <= r_pend_status;
                        o_edges_dropped <= r_ovf;
                        o_last          <= 1'b1;
                        r_pend_v        <= 1'b0;
                        r_state         <= S_IDLE;
                    end
                end
                S_EU_FIND: begin
                    if (r_i >= w_count) begin
                        r_pend_v      <= 1'b1;
                        r_pend_kind   <= KIND_STATUS;
                        r_pend_vertex <= '0;
                        r_pend_status <= EU_CYCLE;
                        r_state       <= S_FLUSH;
                    end else if (r_deg[r_i[VW-1:0]] != 8'd0) begin
                        r_visited     <= MAX_VERTICES'(1) << r_i[VW-1:0];
                        r_stk_ptr[0]  <= r_head[r_i[VW-1:0]];
                        r_stk_left[0] <= r_deg[r_i[VW-1:0]];
                        r_depth       <= SDW'(1);
                        r_walk_out    <= 1'b0;
                        r_state       <= S_WALK_TOP;
                    end else begin
                        r_i <= r_i + NVW'(1);
                    end
                end
                S_EU_SCAN: begin
                    if (r_i >= w_count) begin
                        r_pend_v      <= 1'b1;
                        r_pend_kind   <= KIND_STATUS;
                        r_pend_vertex <= '0;
                        if (r_bad) begin
                            r_pend_status <= EU_NONE;
                        end else if (r_odd == '0) begin
                            r_pend_status <= EU_CYCLE;
                        end else if (r_odd == NVW'(2)) begin
                            r_pend_status <= EU_PATH;
                        end else begin
                            r_pend_status <= EU_NONE;
                        end
                        r_state <= S_FLUSH;
                    end else begin
                        if (r_deg[r_i[VW-1:0]] != 8'd0 && !r_visited[r_i[VW-1:0]]) begin
                            r_bad <= 1'b1;
                        end
                        r_odd <= r_odd + NVW'(r_deg[r_i[VW-1:0]][0]);
                        r_i   <= r_i + NVW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/gde_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module gde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[sv/gde_checker.sv]
// Port-level checks for graph_dfs_eulerian_check, attached by bind.
// Depends on gde_pkg.
`default_nettype none
module gde_port_checks
    import gde_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic [1:0] i_cmd,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_kind,
    input wire logic [3:0] o_vertex,
    input wire logic [1:0] o_euler_status,
    input wire logic       o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_vertex))
        else $error("output transfer changed while stalled");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_STATUS |-> o_last && o_vertex == 4'd0)
        else $error("status result not final");
    a_bad_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_BAD |-> o_last && o_euler_status == EU_NONE)
        else $error("bad start result malformed");
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_WALK || i_cmd == CMD_EULER) |=> !o_in_ready)
        else $error("accepted while walking");
endmodule

bind graph_dfs_eulerian_check gde_port_checks u_gde_port_checks (.*);
`default_nettype wire

[sim/gde_checker.sv]
// Checker for graph_dfs_eulerian_check: watches the command and result channels,
// keeps its own graph model and compares every result transfer. Depends on gde_pkg.
module gde_checker
    import gde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_cmd,
    input  logic [4:0] i_vertex_a,
    input  logic [4:0] i_vertex_b,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_vertex,
    input  logic [1:0] i_euler_status,
    input  logic       i_edges_dropped,
    input  logic       i_last,
    output int         o_errors,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] vertex;
        logic [1:0] status;
        logic       dropped;
        logic       last;
    } t_res;

    t_res        want_q[$];
    logic [4:0]  nv;
    logic [3:0]  nbr [ENTRIES];
    logic [7:0]  nxt [ENTRIES];
    logic [7:0]  head [MAX_VERTICES];
    logic [7:0]  tail [MAX_VERTICES];
    int          deg [MAX_VERTICES];
    int          used;
    bit          seen [MAX_VERTICES];
    bit          dropped;
    int          s_v [MAX_VERTICES];
    int          s_p [MAX_VERTICES];
    int          s_l [MAX_VERTICES];
    int          sp;

    assign o_pending = want_q.size();

    function automatic int live_count();
        return (nv > MAX_VERTICES) ? MAX_VERTICES : int'(nv);
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i < MAX_VERTICES; i++) begin
            head[i] = 8'd0; tail[i] = 8'd0; deg[i] = 0; seen[i] = 1'b0;
        end
        used = 0; sp = 0; dropped = 1'b0;
    endfunction

    function automatic void queue_result(t_res r);
        want_q.insert(want_q.size(), r);
    endfunction

    function automatic void link(int owner, int nb);
        nbr[used] = 4'(nb);
        if (deg[owner] == 0) head[owner] = 8'(used);
        else nxt[tail[owner]] = 8'(used);
        tail[owner] = 8'(used);
        deg[owner]++;
        used++;
    endfunction

    function automatic void visit(int v, bit report, ref int n);
        t_res r;
        seen[v] = 1'b1;
        if (report && n < MAX_OUT) begin
            r = '{KIND_VERTEX, v[3:0], EU_NONE, dropped, 1'b0};
            queue_result(r);
            n++;
        end
        if (sp < MAX_VERTICES) begin
            s_v[sp] = v; s_p[sp] = int'(head[v]); s_l[sp] = deg[v]; sp++;
        end
    endfunction

    function automatic void dfs(int start, int cnt, bit report, ref int n);
        int t, p, nb;
        for (int i = 0; i < MAX_VERTICES; i++) seen[i] = 1'b0;
        sp = 0;
        visit(start, report, n);
        while (sp > 0) begin
            t = sp - 1;
            if (s_l[t] == 0) begin
                sp--;
                continue;
            end
            p = s_p[t];
            if (p >= ENTRIES) p = 0;
            nb = int'(nbr[p]);
            s_l[t]--;
            if (s_l[t] > 0) s_p[t] = int'(nxt[p]);
            if (nb < cnt && !seen[nb]) visit(nb, report, n);
        end
    endfunction

    function automatic logic [1:0] euler_of(int cnt);
        int first, odd, n;
        first = cnt; odd = 0; n = 0;
        for (int i = cnt - 1; i >= 0; i--) if (deg[i] != 0) first = i;
        if (first == cnt) return EU_CYCLE;
        dfs(first, cnt, 1'b0, n);
        for (int i = 0; i < cnt; i++) if (deg[i] != 0 && !seen[i]) return EU_NONE;
        for (int i = 0; i < cnt; i++) if (deg[i] % 2 == 1) odd++;
        if (odd == 0) return EU_CYCLE;
        if (odd == 2) return EU_PATH;
        return EU_NONE;
    endfunction

    function automatic void predict(logic [1:0] cmd, int a, int b);
        int cnt, n;
        t_res r;
        cnt = live_count();
        n = 0;
        case (cmd)
            CMD_ADD: begin
                if (a < cnt && b < cnt) begin
                    if (used + 2 > ENTRIES) dropped = 1'b1;
                    else begin
                        link(a, b);
                        link(b, a);
                    end
                end
            end
            CMD_WALK: begin
                if (a >= cnt) begin
                    r = '{KIND_BAD, 4'd0, EU_NONE, dropped, 1'b1};
                    queue_result(r);
                end else begin
                    dfs(a, cnt, 1'b1, n);
                    want_q[$].last = 1'b1;
                end
            end
            CMD_EULER: begin
                r = '{KIND_STATUS, 4'd0, euler_of(cnt), dropped, 1'b1};
                queue_result(r);
            end
            default: wipe_graph();
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (!i_rst_n) begin
            nv = 5'd16;
            wipe_graph();
            want_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) nv = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                got = '{i_kind, i_vertex, i_euler_status, i_edges_dropped, i_last};
                if (want_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_errors++;
                end else begin
                    exp_r = want_q.pop_front();
                    if (got != exp_r) begin
                        $display({"%0t: mismatch expected kind=%0d vtx=%0d st=%0d drop=%0d",
                            " last=%0d actual kind=%0d vtx=%0d st=%0d drop=%0d last=%0d"},
                            $time, exp_r.kind, exp_r.vertex, exp_r.status, exp_r.dropped,
                            exp_r.last, got.kind, got.vertex, got.status, got.dropped, got.last);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict(i_cmd, int'(i_vertex_a), int'(i_vertex_b));
        end
    end
endmodule

[sim/tb_top.sv]
// Testbench top for graph_dfs_eulerian_check: drives commands, configuration and
// output stalls, and gives the verdict. Depends on gde_pkg and gde_checker.
module tb_top
    import gde_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk, rst_n;
    logic       in_valid, in_ready, cfg_we, out_valid, out_ready;
    logic [1:0] cmd, kind, status;
    logic [4:0] va, vb, cfg_data;
    logic [3:0] vtx;
    logic       dropped, last;
    int         errors, pending;
    int         cycles;
    bit         busy_sink;

    graph_dfs_eulerian_check u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_cmd(cmd), .i_vertex_a(va), .i_vertex_b(vb), .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_kind(kind), .o_vertex(vtx), .o_euler_status(status),
        .o_edges_dropped(dropped), .o_last(last)
    );

    gde_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_cmd(cmd), .i_vertex_a(va), .i_vertex_b(vb), .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_kind(kind), .i_vertex(vtx), .i_euler_status(status),
        .i_edges_dropped(dropped), .i_last(last), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 1000000) begin
                $display("graph_dfs_eulerian_check regression: fail");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    initial begin
        int g;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (busy_sink) out_ready = 1'b1;
            else begin
                g = gap_len();
                out_ready = 1'b0;
                repeat (g) @(negedge clk);
                out_ready = 1'b1;
            end
        end
    end

    task automatic send(logic [1:0] c, logic [4:0] a, logic [4:0] b);
        int g;
        g = gap_len();
        repeat (g) @(negedge clk);
        cmd = c; va = a; vb = b; in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic settle();
        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic set_count(logic [4:0] n);
        settle();
        cfg_data = n; cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_phase(int items, int span);
        logic [1:0] c;
        int r;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 19);
            if (r < 11) c = CMD_ADD;
            else if (r < 15) c = CMD_WALK;
            else if (r < 19) c = CMD_EULER;
            else c = CMD_CLEAR;
            if ($urandom_range(0, 9) == 0)
                send(c, 5'($urandom), 5'($urandom));
            else
                send(c, 5'($urandom_range(0, span - 1)), 5'($urandom_range(0, span - 1)));
        end
    endtask

    initial begin
        rst_n = 1'b0; in_valid = 1'b0; cmd = CMD_ADD; va = 5'd0; vb = 5'd0;
        cfg_we = 1'b0; cfg_data = 5'd0; busy_sink = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        send(CMD_EULER, 5'd0, 5'd0);
        send(CMD_WALK, 5'd15, 5'd0);
        send(CMD_WALK, 5'd16, 5'd0);
        send(CMD_WALK, 5'd31, 5'd0);
        send(CMD_ADD, 5'd31, 5'd0);
        send(CMD_ADD, 5'd0, 5'd1);
        send(CMD_ADD, 5'd1, 5'd2);
        send(CMD_EULER, 5'd0, 5'd0);
        send(CMD_ADD, 5'd2, 5'd0);
        send(CMD_ADD, 5'd3, 5'd3);
        send(CMD_EULER, 5'd0, 5'd0);
        send(CMD_ADD, 5'd15, 5'd14);
        send(CMD_EULER, 5'd0, 5'd0);
        send(CMD_WALK, 5'd0, 5'd0);
        for (int i = 0; i < 15; i++) send(CMD_ADD, 5'(i), 5'(i + 1));
        send(CMD_WALK, 5'd0, 5'd0);
        set_count(5'd3);
        send(CMD_WALK, 5'd0, 5'd0);
        send(CMD_EULER, 5'd0, 5'd0);
        set_count(5'd0);
        send(CMD_EULER, 5'd0, 5'd0);
        send(CMD_WALK, 5'd0, 5'd0);
        set_count(5'd31);
        for (int i = 0; i < 50; i++)
            send(CMD_ADD, 5'($urandom_range(0, 15)), 5'($urandom_range(0, 15)));
        send(CMD_EULER, 5'd0, 5'd0);
        send(CMD_WALK, 5'($urandom_range(0, 15)), 5'd0);
        send(CMD_CLEAR, 5'd0, 5'd0);
        send(CMD_EULER, 5'd0, 5'd0);
        random_phase(15, 16);
        set_count(5'd4);
        send(CMD_CLEAR, 5'd0, 5'd0);
        random_phase(10, 5);
        set_count(5'd1);
        random_phase(5, 2);
        set_count(5'd16);
        send(CMD_CLEAR, 5'd0, 5'd0);
        random_phase(15, 16);
        busy_sink = 1'b1;
        settle();
        if (errors == 0) $display("graph_dfs_eulerian_check regression: pass");
        else $display("graph_dfs_eulerian_check regression: fail");
        $finish;
    end
endmodule

[files.f]
sv/gde_pkg.sv
sv/gde_ram.sv
sv/graph_dfs_eulerian_check.sv
sv/gde_checker.sv
sim/gde_checker.sv
sim/tb_top.sv
